// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Needs clk and arst_n visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge outside reset
`define RQ_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// same-cycle implication
`define RQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define RQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/rqmtf_pkg.sv =====
// Package for the rotating move-to-front queue: sizes, codes, cell bus type.
// No dependencies.
package rqmtf_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int ID_W        = 7;
	localparam int CFG_W       = 7;
	localparam int STATUS_W    = 2;
	localparam int RESET_SIZE  = 64;

	typedef enum logic [0:0] {
		OP_SERVE   = 1'b0,
		OP_PROMOTE = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_SERVED    = 2'd0,
		ST_PROMOTED  = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_EXEC
	} state_t;

	// broadcast from the control to every cell
	typedef struct packed {
		logic             load;
		logic             serve;
		logic             promote;
		logic [CNT_W-1:0] size;
		logic [CNT_W-1:0] last;
		logic [IDX_W-1:0] pos;
		logic [ID_W-1:0]  id;
		logic [ID_W-1:0]  head;
		logic [ID_W-1:0]  probe;
	} cell_bus_t;

	// 0 reads as 1, anything above capacity saturates
	function automatic logic [CNT_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
		logic [CFG_W:0] w;
		w = {1'b0, v};
		if (w == '0) begin
			w = (CFG_W+1)'(1);
		end
		if (int'(w) > MAX_ENTRIES) begin
			w = (CFG_W+1)'(MAX_ENTRIES);
		end
		return CNT_W'(w);
	endfunction

endpackage

// ===== hdl/rqmtf_if.sv =====
// Handshake channels of the queue: request and response words.
// Depends on rqmtf_pkg.
interface rqmtf_req_if;
	logic                       valid;
	logic                       ready;
	logic [0:0]                 opcode;
	logic [rqmtf_pkg::ID_W-1:0] entry_id;

	modport source (output valid, output opcode, output entry_id, input ready);
	modport sink   (input valid, input opcode, input entry_id, output ready);
endinterface

interface rqmtf_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [rqmtf_pkg::ID_W-1:0]     served_id;
	logic [rqmtf_pkg::STATUS_W-1:0] status;

	modport source (output valid, output served_id, output status, input ready);
	modport sink   (input valid, input served_id, input status, output ready);
endinterface

// ===== hdl/rqmtf_cell.sv =====
// One position of the circular order: holds an id, compares it, shifts.
// Depends on rqmtf_pkg.
module rqmtf_cell (
	input  logic                       clk,
	input  logic [rqmtf_pkg::IDX_W-1:0] idx,
	input  rqmtf_pkg::cell_bus_t       bus,
	input  logic [rqmtf_pkg::ID_W-1:0]  left,
	input  logic [rqmtf_pkg::ID_W-1:0]  right,
	output logic [rqmtf_pkg::ID_W-1:0]  id,
	output logic                       hit
);
	import rqmtf_pkg::*;

	logic [ID_W-1:0]  id_q;
	logic [CNT_W-1:0] idx_ext;

	assign idx_ext = CNT_W'(idx);
	assign id      = id_q;
	assign hit     = (id_q == bus.probe);

	always_ff @(posedge clk) begin
		if (bus.load) begin
			id_q <= (idx_ext < bus.size) ? ID_W'(idx_ext + 1'b1) : '0;
		end else if (bus.serve) begin
			if (idx_ext < bus.last) begin
				id_q <= right;
			end else if (idx_ext == bus.last) begin
				id_q <= bus.head;
			end
		end else if (bus.promote && (idx <= bus.pos)) begin
			id_q <= (idx == '0) ? bus.id : left;
		end
	end

endmodule

// ===== hdl/rotating_queue_move_to_front.sv =====
// Top level of the rotating move-to-front queue.
// Depends on rqmtf_pkg, rqmtf_if.sv and rqmtf_cell.
//
// A row of MAX_ENTRIES cells holds the circular order, cell 0 being the
// head. A serve word returns the head id and rotates it to the back of the
// active part; a promote word moves the given id to the head, the others
// keeping their order; an id that is zero or not in the active order leaves
// everything as it was and reports not found. For each request, in the
// accept cycle every cell compares its id against entry_id and the hit
// position is encoded; in the next cycle every cell loads from its
// neighbor and the response word is registered. No new request is taken
// while the previous one is in that shift step. The response register
// lets the next request in while a response still waits, as long as it
// is taken in the cycle of acceptance. After reset the block loads ids
// 1..64 in its init state before it takes requests. Writing queue_size
// (0 reads as 1, above 64 saturates) reloads the order 1..size; write it
// only while the block is idle.
module rotating_queue_move_to_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rqmtf_pkg::CFG_W-1:0] cfg_wdata,
	rqmtf_req_if.sink                  req,
	rqmtf_rsp_if.source                rsp
);
	import rqmtf_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0] size_q;

	// request stage
	op_t             op_s1;
	logic [ID_W-1:0] id_s1;
	logic [IDX_W-1:0] pos_s1;
	logic            found_s1;

	// response register
	logic            rsp_valid_q;
	logic [ID_W-1:0] served_q;
	status_t         status_q;

	cell_bus_t       bus;
	logic [ID_W-1:0] cell_id [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] cell_hit;
	logic [MAX_ENTRIES-1:0] hit_g;
	logic [IDX_W-1:0] pos_c;
	logic            found_c;
	logic            in_ready;
	logic            accept;

	assign in_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept   = req.valid && in_ready;
	assign req.ready = in_ready;

	// cell row; the ends see zero from outside
	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		logic [ID_W-1:0] left_v, right_v;
		if (g == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = cell_id[g-1];
		end
		if (g == MAX_ENTRIES - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = cell_id[g+1];
		end
		rqmtf_cell u_cell (
			.clk   (clk),
			.idx   (IDX_W'(g)),
			.bus   (bus),
			.left  (left_v),
			.right (right_v),
			.id    (cell_id[g]),
			.hit   (cell_hit[g])
		);
	end

	// ids in the order are distinct, so at most one cell hits and an OR
	// of the positions gives the encoded index
	always_comb begin
		pos_c = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit_g[i] = cell_hit[i] && (req.entry_id != '0);
			if (hit_g[i]) begin
				pos_c = pos_c | IDX_W'(i);
			end
		end
		found_c = |hit_g;
	end

	always_comb begin
		bus.load    = (state_q == S_INIT) || cfg_we;
		bus.size    = cfg_we ? clamp_size(cfg_wdata) : size_q;
		bus.last    = size_q - 1'b1;
		bus.serve   = (state_q == S_EXEC) && (op_s1 == OP_SERVE);
		bus.promote = (state_q == S_EXEC) && (op_s1 == OP_PROMOTE) && found_s1;
		bus.pos     = pos_s1;
		bus.id      = id_s1;
		bus.head    = cell_id[0];
		bus.probe   = req.entry_id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: state_d = S_IDLE;
			S_IDLE: if (accept) state_d = S_EXEC;
			S_EXEC: state_d = S_IDLE;
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= clamp_size(CFG_W'(RESET_SIZE));
		end else if (cfg_we) begin
			size_q <= clamp_size(cfg_wdata);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op_t'(req.opcode);
			id_s1    <= req.entry_id;
			pos_s1   <= pos_c;
			found_s1 <= found_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_EXEC) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			if (op_s1 == OP_SERVE) begin
				served_q <= cell_id[0];
				status_q <= ST_SERVED;
			end else begin
				served_q <= '0;
				status_q <= found_s1 ? ST_PROMOTED : ST_NOT_FOUND;
			end
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.served_id = served_q;
	assign rsp.status    = status_q;

endmodule

// ===== hdl/rqmtf_checker.sv =====
// Port-level checks for the rotating move-to-front queue, bound to the top.
// Depends on rqmtf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rqmtf_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [rqmtf_pkg::ID_W-1:0]     served_id,
	input logic [rqmtf_pkg::STATUS_W-1:0] status
);
	import rqmtf_pkg::*;

	logic req_acc;
	assign req_acc = req_valid && req_ready;

	// status code only takes the three defined values
	`RQ_ASSERT_IMP(a_status_code, rsp_valid, (status == ST_SERVED) || (status == ST_PROMOTED) || (status == ST_NOT_FOUND))
	// served ids are never zero, other results carry zero
	`RQ_ASSERT_IMP(a_served_id, rsp_valid, (status == ST_SERVED) == (served_id != '0))
	// every request is answered, the response registered from the exec state after acceptance
	`RQ_ASSERT_IMP(a_rsp_latency, $past(req_acc, 2), rsp_valid)
	// one request in flight: no acceptance in the cycle after one
	`RQ_ASSERT_NXT(a_one_in_flight, req_acc, !req_ready)
	// a stalled response holds its word
	`RQ_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(served_id) && $stable(status))

endmodule

bind rotating_queue_move_to_front rqmtf_checker u_rqmtf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.served_id (rsp.served_id),
	.status    (rsp.status)
);
